/* rtl/fp64_next_after_fp32_direction_assert.svh */
// Assertion macros for the next-after block
`ifndef FP64_NEXT_AFTER_FP32_DIRECTION_ASSERT_SVH
`define FP64_NEXT_AFTER_FP32_DIRECTION_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define NA_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define NA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* rtl/fnafd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fnafd_pkg
// Constants and types shared by the next-after datapath.
// ----------------------------------------------------------------------------
package fnafd_pkg;
   localparam logic [63:0] SIGN64  = 64'h8000_0000_0000_0000;
   localparam logic [63:0] EXP64   = 64'h7FF0_0000_0000_0000;
   localparam logic [63:0] QNAN64  = 64'h7FF8_0000_0000_0000;
   localparam logic [63:0] MINNORM = 64'h0010_0000_0000_0000;

   typedef struct packed {
      logic [63:0] bits;
      logic        ovf;
      logic        unf;
   } result_type;
endpackage
`default_nettype wire

/* rtl/fnafd_widen.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fnafd_widen
// Exact widening of a binary32 pattern to binary64 (NaN not handled).
// ----------------------------------------------------------------------------
module fnafd_widen (
   input  wire logic [31:0] y_bits,
   output logic      [63:0] y_wide
);
   import fnafd_pkg::*;

   logic [7:0]  exp_s;
   logic [22:0] man_s;
   logic [4:0]  lead;
   logic [63:0] shifted;

   assign exp_s = y_bits[30:23];
   assign man_s = y_bits[22:0];

   // leading-one position of a subnormal mantissa
   always_comb begin
      lead = 5'd0;
      for (int i = 0; i < 23; i++) begin
         if (man_s[i]) lead = 5'(i);
      end
   end

   assign shifted = {41'd0, man_s} << (6'd52 - {1'b0, lead});

   always_comb begin
      if (exp_s == 8'hFF) begin
         y_wide = {y_bits[31], 63'd0} | EXP64;
      end else if (exp_s == 8'd0) begin
         if (man_s == 23'd0) y_wide = {y_bits[31], 63'd0};
         else y_wide = {y_bits[31], 11'({6'd0, lead} + 11'd874), shifted[51:0]};
      end else begin
         y_wide = {y_bits[31], 11'({3'd0, exp_s} + 11'd896), man_s, 29'd0};
      end
   end
endmodule
`default_nettype wire

/* rtl/fnafd_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fnafd_core
// Case selection and one-unit step of the binary64 pattern.
// ----------------------------------------------------------------------------
module fnafd_core (
   input  wire logic [63:0]            x_bits,
   input  wire logic [31:0]            y_bits,
   output fnafd_pkg::result_type       res
);
   import fnafd_pkg::*;

   logic [63:0] yd, kx, ky, stepped;
   logic        x_nan, y_nan, x_zero, y_zero, xgt, shrink;

   fnafd_widen u_widen (.y_bits(y_bits), .y_wide(yd));

   assign x_nan  = (x_bits[62:52] == 11'h7FF) && (x_bits[51:0] != 52'd0);
   assign y_nan  = (y_bits[30:23] == 8'hFF) && (y_bits[22:0] != 23'd0);
   assign x_zero = (x_bits[62:0] == 63'd0);
   assign y_zero = (yd[62:0] == 63'd0);

   // order keys: monotone unsigned mapping of the float ordering
   assign kx = x_zero ? SIGN64 : (x_bits[63] ? ~x_bits : (x_bits | SIGN64));
   assign ky = y_zero ? SIGN64 : (yd[63] ? ~yd : (yd | SIGN64));
   assign xgt    = kx > ky;
   assign shrink = x_bits[63] ? ~xgt : xgt;
   assign stepped = shrink ? x_bits - 64'd1 : x_bits + 64'd1;

   always_comb begin
      res.bits = x_bits;
      res.ovf  = 1'b0;
      res.unf  = 1'b0;
      if (x_nan) begin
         res.bits = x_bits;
      end else if (y_nan) begin
         res.bits = QNAN64;
      end else if ((x_zero && y_zero) || (x_bits[62:0] == EXP64[62:0]) || (kx == ky)) begin
         res.bits = x_bits;
      end else if (x_zero) begin
         res.bits = MINNORM | (xgt ? SIGN64 : 64'd0);
      end else begin
         res.bits = stepped;
         res.ovf  = (stepped[62:0] == EXP64[62:0]);
         res.unf  = (stepped[62:0] == 63'd0);
      end
   end
endmodule
`default_nettype wire

/* rtl/fp64_next_after_fp32_direction.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fp64_next_after_fp32_direction
// Neighbor of a binary64 value toward a binary32 direction value.
// ----------------------------------------------------------------------------
//  channel | ports                  | handshake
//  request | req_x_bits, req_y_bits | start & !busy
//  result  | rsp_*                  | rsp_valid, one cycle
//
// The result passes an input register, then a result register.
// One word per cycle; busy is always low.
// Synchronous reset clears the valid bits only.
// The receiver cannot stall, so results are never held.
module fp64_next_after_fp32_direction (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [63:0] req_x_bits,
   input  wire logic [31:0] req_y_bits,
   output logic             rsp_valid,
   output logic      [63:0] rsp_result_bits,
   output logic             rsp_overflow_flag,
   output logic             rsp_underflow_flag,
   output logic             rsp_inexact_flag
);
   import fnafd_pkg::*;
`include "fp64_next_after_fp32_direction_assert.svh"

   logic        in_vld_ff, out_vld_ff;
   logic [63:0] x_ff;
   logic [31:0] y_ff;
   result_type  res_in, res_ff;

   assign busy = 1'b0;

   // input register
   always_ff @(posedge clock) begin
      if (reset) in_vld_ff <= 1'b0;
      else in_vld_ff <= start;
      if (start) begin
         x_ff <= req_x_bits;
         y_ff <= req_y_bits;
      end
   end

   fnafd_core u_core (.x_bits(x_ff), .y_bits(y_ff), .res(res_in));

   // result register
   always_ff @(posedge clock) begin
      if (reset) out_vld_ff <= 1'b0;
      else out_vld_ff <= in_vld_ff;
      res_ff <= res_in;
   end

   assign rsp_valid          = out_vld_ff;
   assign rsp_result_bits    = res_ff.bits;
   assign rsp_overflow_flag  = res_ff.ovf;
   assign rsp_underflow_flag = res_ff.unf;
   assign rsp_inexact_flag   = res_ff.ovf | res_ff.unf;

   `NA_ASSERT_NEXT(a_lat, clock, reset, start, ##1 rsp_valid)
   `NA_ASSERT_IMP(a_flags, clock, reset, rsp_valid, !(rsp_overflow_flag && rsp_underflow_flag))
   `NA_ASSERT_IMP(a_ovf, clock, reset, rsp_valid && rsp_overflow_flag,
                  rsp_result_bits[62:52] == 11'h7FF && rsp_result_bits[51:0] == 52'd0)
endmodule
`default_nettype wire

/* dv/fp64_next_after_fp32_direction_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fp64_next_after_fp32_direction_test
// Self-checking bench for the binary64 next-after unit. Each accepted request
// word is predicted with a bit-level neighbor calculation and queued; every
// response word is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module fp64_next_after_fp32_direction_test;
   import fnafd_pkg::*;

   typedef struct {
      logic [63:0] x;
      logic [31:0] y;
   } operand_pair_type;

   typedef struct {
      logic [63:0] bits;
      logic        ovf;
      logic        unf;
      logic        inx;
   } neighbor_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [63:0] req_x_bits = '0;
   logic [31:0] req_y_bits = '0;
   logic        rsp_valid;
   logic [63:0] rsp_result_bits;
   logic        rsp_overflow_flag;
   logic        rsp_underflow_flag;
   logic        rsp_inexact_flag;

   operand_pair_type pending_ops[$];
   neighbor_type     expected_neighbors[$];
   int               error_count = 0;
   int               checked_count = 0;
   int               idle_left = 0;
   bit               allow_idle = 1;
   operand_pair_type cur_op;

   fp64_next_after_fp32_direction dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_x_bits(req_x_bits), .req_y_bits(req_y_bits),
      .rsp_valid(rsp_valid), .rsp_result_bits(rsp_result_bits),
      .rsp_overflow_flag(rsp_overflow_flag),
      .rsp_underflow_flag(rsp_underflow_flag),
      .rsp_inexact_flag(rsp_inexact_flag)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // exact binary32 -> binary64 widening of a non-NaN pattern
   function automatic logic [63:0] widen_single(logic [31:0] y);
      logic [63:0] s;
      logic [7:0]  e;
      logic [22:0] m;
      int          p;
      s = {y[31], 63'b0};
      e = y[30:23];
      m = y[22:0];
      if (e == 8'hFF) return s | EXP64;
      if (e == 8'h00) begin
         if (m == 0) return s;
         p = 22;
         while (p > 0 && m[p] == 1'b0) p--;
         return s | (64'(p + 874) << 52) | ((64'(m) << (52 - p)) & ~(SIGN64 | EXP64));
      end
      return s | (64'(e + 896) << 52) | (64'(m) << 29);
   endfunction

   // monotone ordering key; both zeros collapse
   function automatic logic [63:0] magnitude_order(logic [63:0] b);
      if ((b & ~SIGN64) == 0) return SIGN64;
      if (b[63]) return ~b;
      return b | SIGN64;
   endfunction

   function automatic neighbor_type predict_neighbor(logic [63:0] x, logic [31:0] y);
      neighbor_type r;
      logic [63:0]  yd, kx, ky;
      r = '{bits: x, ovf: 1'b0, unf: 1'b0, inx: 1'b0};
      if (x[62:52] == 11'h7FF && x[51:0] != 0) return r;
      if (y[30:23] == 8'hFF && y[22:0] != 0) begin
         r.bits = QNAN64;
         return r;
      end
      yd = widen_single(y);
      kx = magnitude_order(x);
      ky = magnitude_order(yd);
      if ((x & ~SIGN64) == 0 && (yd & ~SIGN64) == 0) return r;
      if ((x & ~SIGN64) == EXP64) return r;
      if (kx == ky) return r;
      if ((x & ~SIGN64) == 0) begin
         r.bits = MINNORM | ((kx > ky) ? SIGN64 : 64'b0);
         return r;
      end
      // shrink toward zero when x is on the far side of y
      r.bits = ((x[63] ? !(kx > ky) : (kx > ky))) ? x - 1 : x + 1;
      if ((r.bits & ~SIGN64) == EXP64) r.ovf = 1'b1;
      else if ((r.bits & ~SIGN64) == 0) r.unf = 1'b1;
      r.inx = r.ovf | r.unf;
      return r;
   endfunction

   function automatic logic [31:0] random_single();
      case ($urandom_range(0, 7))
         0: return {$urandom_range(0, 1) == 1, 8'h00, 23'($urandom)};
         1: return {$urandom_range(0, 1) == 1, 8'hFF, 23'($urandom_range(0, 3))};
         2: return {$urandom_range(0, 1) == 1, 31'b0};
         default: return $urandom;
      endcase
   endfunction

   // x often placed next to widened y to hit equality and near-boundary steps
   function automatic logic [63:0] random_double(logic [31:0] y);
      logic [63:0] w;
      case ($urandom_range(0, 9))
         0: return {$urandom, $urandom} & ~64'h000F_FFFF_FFFF_FFF0 | 64'(4'($urandom));
         1: return {$urandom_range(0, 1) == 1, 11'h7FF, 52'($urandom_range(0, 2))};
         2: return {$urandom_range(0, 1) == 1, 11'h000, 20'b0, 32'($urandom_range(0, 2))};
         3: return {$urandom_range(0, 1) == 1, 11'h7FE, {52{1'b1}}} - 64'($urandom_range(0, 1));
         4, 5: begin
            if (y[30:23] == 8'hFF && y[22:0] != 0) return {$urandom, $urandom};
            w = widen_single(y);
            return w + 64'($signed($urandom_range(0, 4)) - 2);
         end
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic queue_pair(logic [63:0] x, logic [31:0] y);
      pending_ops.push_back('{x: x, y: y});
   endtask

   // sample acceptance and results at the rising edge
   always @(posedge clock) begin
      neighbor_type e;
      if (!reset && start && !busy)
         expected_neighbors.push_back(predict_neighbor(req_x_bits, req_y_bits));
      if (!reset && rsp_valid) begin
         checked_count++;
         if (expected_neighbors.size() == 0) begin
            $display("%0t: unexpected word, got %h", $time, rsp_result_bits);
            error_count++;
         end else begin
            e = expected_neighbors.pop_front();
            if (rsp_result_bits !== e.bits || rsp_overflow_flag !== e.ovf ||
                rsp_underflow_flag !== e.unf || rsp_inexact_flag !== e.inx) begin
               $display("%0t: mismatch, expected %h o%b u%b i%b, actual %h o%b u%b i%b",
                        $time, e.bits, e.ovf, e.unf, e.inx, rsp_result_bits,
                        rsp_overflow_flag, rsp_underflow_flag, rsp_inexact_flag);
               error_count++;
            end
         end
      end
   end

   // feed one word per accepted handshake, with random idle bursts
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && busy) begin
         // hold the current word until accepted
      end else if (idle_left > 0) begin
         idle_left <= idle_left - 1;
         start     <= 1'b0;
      end else if (allow_idle && $urandom_range(0, 7) == 0) begin
         idle_left <= $urandom_range(0, 5);
         start     <= 1'b0;
      end else if (pending_ops.size() > 0) begin
         cur_op      = pending_ops.pop_front();
         req_x_bits <= cur_op.x;
         req_y_bits <= cur_op.y;
         start      <= 1'b1;
      end else begin
         start <= 1'b0;
      end
   end

   initial begin
      logic [31:0] y;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      // directed corners
      queue_pair(64'h7FF0_0000_0000_0001, 32'h3F80_0000);  // NaN x
      queue_pair(64'hFFF8_0000_0000_0000, 32'h7FC0_0000);  // NaN x, NaN y
      queue_pair(64'h3FF0_0000_0000_0000, 32'h7F80_0001);  // NaN y
      queue_pair(64'h0000_0000_0000_0000, 32'h8000_0000);  // both zero
      queue_pair(64'h8000_0000_0000_0000, 32'h0000_0000);
      queue_pair(64'h7FF0_0000_0000_0000, 32'h0000_0000);  // infinite x
      queue_pair(64'hFFF0_0000_0000_0000, 32'h3F80_0000);
      queue_pair(64'h3FF0_0000_0000_0000, 32'h3F80_0000);  // equal
      queue_pair(64'h7FF0_0000_0000_0000, 32'h7F80_0000);
      queue_pair(64'h0000_0000_0000_0000, 32'h3F80_0000);  // zero x up
      queue_pair(64'h8000_0000_0000_0000, 32'hBF80_0000);  // zero x down
      queue_pair(64'h7FEF_FFFF_FFFF_FFFF, 32'h7F80_0000);  // overflow
      queue_pair(64'hFFEF_FFFF_FFFF_FFFF, 32'hFF80_0000);
      queue_pair(64'h0000_0000_0000_0001, 32'h0000_0000);  // underflow
      queue_pair(64'h8000_0000_0000_0001, 32'h3F80_0000);
      queue_pair(64'h3FF0_0000_0000_0000, 32'h0000_0001);  // subnormal y
      queue_pair(64'h36A0_0000_0000_0000, 32'h0000_0001);
      queue_pair(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
      queue_pair(64'h0010_0000_0000_0000, 32'h0000_0000);  // normal to subnormal
      queue_pair(64'hBFF0_0000_0000_0000, 32'hC000_0000);
      for (int i = 0; i < 1600; i++) begin
         y = random_single();
         queue_pair(random_double(y), y);
         if (i == 1300) begin
            wait (pending_ops.size() < 300);
            allow_idle = 0;
         end
      end
      wait (pending_ops.size() == 0 && !start);
      wait (expected_neighbors.size() == 0);
      repeat (8) @(posedge clock);
      $display("Checked %0d result words across NaN, zero, infinity, equality,", checked_count);
      $display("overflow, underflow and random neighbor steps.");
      if (error_count == 0 && expected_neighbors.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAILED: results differ");
      $finish;
   end
endmodule

/* files.f */
+incdir+rtl
rtl/fnafd_pkg.sv
rtl/fnafd_widen.sv
rtl/fnafd_core.sv
rtl/fp64_next_after_fp32_direction.sv
dv/fp64_next_after_fp32_direction_test.sv
